// ===== design/brl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_pkg
// shared types and fixed widths of the line rasterizer
// ----------------------------------------------------------------------------
package brl_pkg;

    localparam int ADDR_BITS  = 22;
    localparam int PITCH_BITS = 12;
    localparam int COLOR_BITS = 8;

    localparam logic [PITCH_BITS-1:0] PITCH_RESET = 12'd640;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

endpackage

// ===== design/brl_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl channel interfaces
// command, pixel and pitch configuration channels with valid/ready
// ----------------------------------------------------------------------------

interface brl_cmd_if #(parameter int COORD_BITS = 11);
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic [COORD_BITS-1:0]               x_start;
    logic [COORD_BITS-1:0]               y_start;
    logic [COORD_BITS-1:0]               x_end;
    logic [COORD_BITS-1:0]               y_end;
    logic [brl_pkg::COLOR_BITS-1:0]      color;

    modport source (output valid, op, x_start, y_start, x_end, y_end, color, input ready);
    modport sink   (input valid, op, x_start, y_start, x_end, y_end, color, output ready);
endinterface

interface brl_pix_if;
    logic                                valid;
    logic                                ready;
    logic                                pixel_valid;
    logic [brl_pkg::ADDR_BITS-1:0]       pixel_address;
    logic [brl_pkg::COLOR_BITS-1:0]      pixel_color;
    logic                                last_pixel;

    modport source (output valid, pixel_valid, pixel_address, pixel_color, last_pixel,
                    input ready);
    modport sink   (input valid, pixel_valid, pixel_address, pixel_color, last_pixel,
                    output ready);
endinterface

interface brl_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [brl_pkg::PITCH_BITS-1:0]      line_pitch;

    modport source (output valid, line_pitch, input ready);
    modport sink   (input valid, line_pitch, output ready);
endinterface

// ===== design/bresenham_line_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// integer line stepper producing frame buffer byte addresses, one per command
// ----------------------------------------------------------------------------
// usage:
//   cmd   - command channel; a start command loads both end points and the
//           color and yields the first pixel, a step command yields the next
//   pixel - one result per command; pixel_valid low means a step arrived with
//           no line in progress, last_pixel marks the line's end point
//   cfg   - write of line_pitch (row stride in bytes), always ready; write it
//           only while no command is in flight
// timing:
//   a command transfer is held in the input register, then its result in the
//   result register; one command per cycle is sustained while pixel.ready
//   stays high, the only recurrence being the update of the line state
//   (error term, coordinates, incremental address)
//   a start command spends one 11x12 multiply on the first row address
// reset:
//   no line active, both registers empty, line_pitch back to 640
// backpressure:
//   while the result waits on pixel.ready the input register still takes one
//   more command; after that cmd.ready drops until the result is taken
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer #(
    parameter int COORD_BITS = 11
) (
    input  logic         clk,
    input  logic         rst_n,
    brl_cmd_if.sink      cmd,
    brl_pix_if.source    pixel,
    brl_cfg_if.sink      cfg
);

    localparam int SPAN_BITS = COORD_BITS + 1;   // doubled span
    localparam int ERR_BITS  = COORD_BITS + 3;   // signed error term
    localparam int PROD_BITS = COORD_BITS + brl_pkg::PITCH_BITS;
    localparam int AW        = brl_pkg::ADDR_BITS;

    // configuration
    logic [brl_pkg::PITCH_BITS-1:0] pitch_reg;

    // input register
    logic                           in_vld_reg;
    logic                           in_op_reg;
    logic [COORD_BITS-1:0]          in_xs_reg;
    logic [COORD_BITS-1:0]          in_ys_reg;
    logic [COORD_BITS-1:0]          in_xe_reg;
    logic [COORD_BITS-1:0]          in_ye_reg;
    logic [brl_pkg::COLOR_BITS-1:0] in_color_reg;

    // line state
    logic                           active_reg,  active_next;
    logic [COORD_BITS-1:0]          cur_x_reg,   cur_x_next;
    logic [COORD_BITS-1:0]          cur_y_reg,   cur_y_next;
    logic [COORD_BITS-1:0]          end_x_reg,   end_x_next;
    logic [COORD_BITS-1:0]          end_y_reg,   end_y_next;
    logic [SPAN_BITS-1:0]           span_x_reg,  span_x_next;
    logic [SPAN_BITS-1:0]           span_y_reg,  span_y_next;
    logic                           x_down_reg,  x_down_next;
    logic                           y_down_reg,  y_down_next;
    logic                           y_major_reg, y_major_next;
    logic signed [ERR_BITS-1:0]     err_reg,     err_next;
    logic [brl_pkg::COLOR_BITS-1:0] color_reg,   color_next;
    logic [AW-1:0]                  addr_reg,    addr_next;

    // result register
    logic                           out_vld_reg;
    logic                           out_pv_reg,    out_pv_next;
    logic [AW-1:0]                  out_addr_reg,  out_addr_next;
    logic [brl_pkg::COLOR_BITS-1:0] out_color_reg, out_color_next;
    logic                           out_last_reg,  out_last_next;

    // datapath intermediates
    logic                           process;
    logic                           cmd_xfer;
    logic [COORD_BITS-1:0]          span_x_abs;
    logic [COORD_BITS-1:0]          span_y_abs;
    logic [PROD_BITS-1:0]           row_prod;
    logic                           err_ge;
    logic                           move_x;
    logic                           move_y;
    logic [AW-1:0]                  addr_dx;
    logic [AW-1:0]                  addr_dy;
    logic                           last;

    // the computing stage fires when it holds a command and the result slot frees
    assign process  = in_vld_reg && (!out_vld_reg || pixel.ready);
    assign cmd.ready = !in_vld_reg || process;
    assign cmd_xfer = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    assign pixel.valid         = out_vld_reg;
    assign pixel.pixel_valid   = out_pv_reg;
    assign pixel.pixel_address = out_addr_reg;
    assign pixel.pixel_color   = out_color_reg;
    assign pixel.last_pixel    = out_last_reg;

    always_comb
    begin
        // hold by default
        active_next  = active_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        end_x_next   = end_x_reg;
        end_y_next   = end_y_reg;
        span_x_next  = span_x_reg;
        span_y_next  = span_y_reg;
        x_down_next  = x_down_reg;
        y_down_next  = y_down_reg;
        y_major_next = y_major_reg;
        err_next     = err_reg;
        color_next   = color_reg;
        addr_next    = addr_reg;

        // start: spans, direction, major axis, initial error, first address
        span_x_abs = (in_xe_reg < in_xs_reg) ? (in_xs_reg - in_xe_reg)
                                             : (in_xe_reg - in_xs_reg);
        span_y_abs = (in_ye_reg < in_ys_reg) ? (in_ys_reg - in_ye_reg)
                                             : (in_ye_reg - in_ys_reg);
        row_prod   = PROD_BITS'(in_ys_reg) * PROD_BITS'(pitch_reg);

        // step: both axes may move, the minor one only when the error is non-negative
        err_ge  = !err_reg[ERR_BITS-1];
        move_x  = y_major_reg ? err_ge : 1'b1;
        move_y  = y_major_reg ? 1'b1   : err_ge;
        addr_dx = !move_x     ? '0
                : x_down_reg  ? {AW{1'b1}}
                :               AW'(1);
        addr_dy = !move_y     ? '0
                : y_down_reg  ? (AW'(0) - AW'(pitch_reg))
                :               AW'(pitch_reg);

        if (in_op_reg == brl_pkg::OP_START)
        begin
            cur_x_next   = in_xs_reg;
            cur_y_next   = in_ys_reg;
            end_x_next   = in_xe_reg;
            end_y_next   = in_ye_reg;
            x_down_next  = in_xe_reg < in_xs_reg;
            y_down_next  = in_ye_reg < in_ys_reg;
            span_x_next  = {span_x_abs, 1'b0};
            span_y_next  = {span_y_abs, 1'b0};
            y_major_next = span_x_abs <= span_y_abs;
            // halving a doubled span gives back the plain span
            if (y_major_next)
            begin
                err_next = $signed({2'b00, span_x_next}) - $signed({3'b000, span_y_abs});
            end
            else
            begin
                err_next = $signed({2'b00, span_y_next}) - $signed({3'b000, span_x_abs});
            end
            color_next   = in_color_reg;
            addr_next    = AW'(row_prod) + AW'(in_xs_reg);
            active_next  = 1'b1;
        end
        else if (active_reg)
        begin
            if (y_major_reg)
            begin
                err_next = err_reg
                         - (err_ge ? $signed({2'b00, span_y_reg}) : $signed(ERR_BITS'(0)))
                         + $signed({2'b00, span_x_reg});
            end
            else
            begin
                err_next = err_reg
                         - (err_ge ? $signed({2'b00, span_x_reg}) : $signed(ERR_BITS'(0)))
                         + $signed({2'b00, span_y_reg});
            end
            if (move_x)
            begin
                cur_x_next = x_down_reg ? (cur_x_reg - 1'b1) : (cur_x_reg + 1'b1);
            end
            if (move_y)
            begin
                cur_y_next = y_down_reg ? (cur_y_reg - 1'b1) : (cur_y_reg + 1'b1);
            end
            addr_next = addr_reg + addr_dx + addr_dy;
        end

        // the line ends when the major coordinate reaches its end value
        last = y_major_next ? (cur_y_next == end_y_next) : (cur_x_next == end_x_next);

        if ((in_op_reg == brl_pkg::OP_START) || active_reg)
        begin
            out_pv_next    = 1'b1;
            out_addr_next  = addr_next;
            out_color_next = color_next;
            out_last_next  = last;
            if (last)
            begin
                active_next = 1'b0;
            end
        end
        else
        begin
            // step with no line: empty result
            out_pv_next    = 1'b0;
            out_addr_next  = '0;
            out_color_next = '0;
            out_last_next  = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg   <= brl_pkg::PITCH_RESET;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            active_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                pitch_reg <= cfg.line_pitch;
            end
            if (cmd_xfer)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (process)
            begin
                in_vld_reg <= 1'b0;
            end
            if (process)
            begin
                out_vld_reg <= 1'b1;
                active_reg  <= active_next;
            end
            else if (pixel.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload and line registers
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            in_op_reg    <= cmd.op;
            in_xs_reg    <= cmd.x_start;
            in_ys_reg    <= cmd.y_start;
            in_xe_reg    <= cmd.x_end;
            in_ye_reg    <= cmd.y_end;
            in_color_reg <= cmd.color;
        end
        if (process)
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            end_x_reg     <= end_x_next;
            end_y_reg     <= end_y_next;
            span_x_reg    <= span_x_next;
            span_y_reg    <= span_y_next;
            x_down_reg    <= x_down_next;
            y_down_reg    <= y_down_next;
            y_major_reg   <= y_major_next;
            err_reg       <= err_next;
            color_reg     <= color_next;
            addr_reg      <= addr_next;
            out_pv_reg    <= out_pv_next;
            out_addr_reg  <= out_addr_next;
            out_color_reg <= out_color_next;
            out_last_reg  <= out_last_next;
        end
    end

endmodule

// ===== design/brl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_checker
// port-level checks of the line rasterizer, bound to its top level
// ----------------------------------------------------------------------------
module brl_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cmd_valid,
    input logic                           cmd_ready,
    input logic                           pix_valid,
    input logic                           pix_ready,
    input logic                           pixel_valid,
    input logic [brl_pkg::ADDR_BITS-1:0]  pixel_address,
    input logic [brl_pkg::COLOR_BITS-1:0] pixel_color,
    input logic                           last_pixel
);

    // a stalled result holds its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid && $stable(pixel_valid)
            && $stable(pixel_address) && $stable(pixel_color) && $stable(last_pixel))
        else $error("pixel payload changed while stalled");

    // an empty result carries all-zero fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pixel_valid |-> pixel_address == '0 && pixel_color == '0 && !last_pixel)
        else $error("empty result with nonzero fields");

    // only a real pixel can end a line
    a_last_real: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && last_pixel |-> pixel_valid)
        else $error("last_pixel on an empty result");

    // a fresh result traces back to a command transfer through the input register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix_valid) |-> $past(cmd_valid && cmd_ready, 2))
        else $error("result appeared without a matching command transfer");

endmodule

bind bresenham_line_rasterizer brl_checker u_brl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .pix_valid     (pixel.valid),
    .pix_ready     (pixel.ready),
    .pixel_valid   (pixel.pixel_valid),
    .pixel_address (pixel.pixel_address),
    .pixel_color   (pixel.pixel_color),
    .last_pixel    (pixel.last_pixel)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bresenham line rasterizer: a queue-fed command
// driver, a pixel monitor that checks every transfer against a cycle-free
// line stepper, random stalls on both channels and pitch changes between
// phases
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ADDR_BITS      = brl_pkg::ADDR_BITS;
    localparam int PITCH_BITS     = brl_pkg::PITCH_BITS;
    localparam int COLOR_BITS     = brl_pkg::COLOR_BITS;
    localparam int COORD_BITS     = 11;
    localparam int ROW_BITS       = ADDR_BITS + COORD_BITS + PITCH_BITS;
    localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
    localparam int STALL_PERCENT  = 11;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PRINT_LIMIT    = 30;

    // one command as it goes onto the cmd channel
    typedef struct packed
    {
        brl_pkg::op_t          op;
        logic [COORD_BITS-1:0] xs;
        logic [COORD_BITS-1:0] ys;
        logic [COORD_BITS-1:0] xe;
        logic [COORD_BITS-1:0] ye;
        logic [COLOR_BITS-1:0] color;
    } line_cmd_t;

    // one pixel result as it should leave the block
    typedef struct packed
    {
        logic                  valid;
        logic [ADDR_BITS-1:0]  address;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } pixel_t;

    logic clk;
    logic rst_n;

    brl_cmd_if #(.COORD_BITS(COORD_BITS)) cmd_if ();
    brl_pix_if                            pix_if ();
    brl_cfg_if                            cfg_if ();

    bresenham_line_rasterizer #(
        .COORD_BITS (COORD_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .pixel (pix_if),
        .cfg   (cfg_if)
    );

    // commands waiting for the driver, pixels waiting for the monitor
    line_cmd_t cmds_to_send[$];
    pixel_t    pixels_due[$];

    line_cmd_t on_bus;
    pixel_t    next_pixel;
    pixel_t    got_pixel;
    int        fail_count;
    int        quiet_cycles;
    logic      no_stall;

    // ------------------------------------------------------------------------
    // line stepper state, mirrors the block's registers after reset
    // ------------------------------------------------------------------------
    logic [PITCH_BITS-1:0] lr_pitch  = brl_pkg::PITCH_RESET;
    logic                  lr_active = 1'b0;
    logic [COORD_BITS-1:0] lr_x      = '0;
    logic [COORD_BITS-1:0] lr_y      = '0;
    logic [COORD_BITS-1:0] lr_end_x  = '0;
    logic [COORD_BITS-1:0] lr_end_y  = '0;
    int                    lr_span_x2 = 0;
    int                    lr_span_y2 = 0;
    logic                  lr_x_down = 1'b0;
    logic                  lr_y_down = 1'b0;
    logic                  lr_y_major = 1'b0;
    int                    lr_err    = 0;
    logic [COLOR_BITS-1:0] lr_color  = '0;
    logic [ADDR_BITS-1:0]  lr_addr   = '0;

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // line stepper
    // ------------------------------------------------------------------------

    // move one column, address follows by one byte
    function automatic void walk_x();
        if (lr_x_down)
        begin
            lr_x    = lr_x - 1'b1;
            lr_addr = lr_addr - 1'b1;
        end
        else
        begin
            lr_x    = lr_x + 1'b1;
            lr_addr = lr_addr + 1'b1;
        end
    endfunction

    // move one row, address follows by one pitch
    function automatic void walk_y();
        if (lr_y_down)
        begin
            lr_y    = lr_y - 1'b1;
            lr_addr = lr_addr - ADDR_BITS'(lr_pitch);
        end
        else
        begin
            lr_y    = lr_y + 1'b1;
            lr_addr = lr_addr + ADDR_BITS'(lr_pitch);
        end
    endfunction

    // pixel caused by one command; updates the line state
    function automatic pixel_t rasterize(line_cmd_t c);
        pixel_t              px;
        logic [ROW_BITS-1:0] row_addr;
        px = '0;
        if (c.op == brl_pkg::OP_START)
        begin
            lr_x       = c.xs;
            lr_y       = c.ys;
            lr_end_x   = c.xe;
            lr_end_y   = c.ye;
            lr_x_down  = c.xe < c.xs;
            lr_y_down  = c.ye < c.ys;
            lr_span_x2 = 2 * (lr_x_down ? int'(c.xs) - int'(c.xe) : int'(c.xe) - int'(c.xs));
            lr_span_y2 = 2 * (lr_y_down ? int'(c.ys) - int'(c.ye) : int'(c.ye) - int'(c.ys));
            // ties go to the y axis, the single point included
            lr_y_major = lr_span_x2 <= lr_span_y2;
            lr_err     = lr_y_major ? lr_span_x2 - lr_span_y2 / 2
                                    : lr_span_y2 - lr_span_x2 / 2;
            lr_color   = c.color;
            row_addr   = ROW_BITS'(c.ys) * ROW_BITS'(lr_pitch) + ROW_BITS'(c.xs);
            lr_addr    = row_addr[ADDR_BITS-1:0];
            lr_active  = 1'b1;
        end
        else if (!lr_active)
            return px;
        else if (lr_y_major)
        begin
            if (lr_err >= 0)
            begin
                lr_err = lr_err - lr_span_y2;
                walk_x();
            end
            lr_err = lr_err + lr_span_x2;
            walk_y();
        end
        else
        begin
            if (lr_err >= 0)
            begin
                lr_err = lr_err - lr_span_x2;
                walk_y();
            end
            lr_err = lr_err + lr_span_y2;
            walk_x();
        end
        px.valid   = 1'b1;
        px.address = lr_addr;
        px.color   = lr_color;
        px.last    = lr_y_major ? (lr_y == lr_end_y) : (lr_x == lr_end_x);
        if (px.last)
            lr_active = 1'b0;
        return px;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // command driver: payload held while valid waits for ready, a random
    // stall in about one cycle of nine unless no_stall is set
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            cmd_if.valid <= 1'b0;
        else
        begin
            // predict at the transfer, so the pixel order follows the commands
            if (cmd_if.valid && cmd_if.ready)
            begin
                next_pixel = rasterize(on_bus);
                pixels_due.push_back(next_pixel);
            end
            if (!cmd_if.valid || cmd_if.ready)
            begin
                if (cmds_to_send.size() != 0 &&
                    (no_stall || $urandom_range(0, 99) >= STALL_PERCENT))
                begin
                    on_bus = cmds_to_send.pop_front();
                    cmd_if.valid   <= 1'b1;
                    cmd_if.op      <= on_bus.op;
                    cmd_if.x_start <= on_bus.xs;
                    cmd_if.y_start <= on_bus.ys;
                    cmd_if.x_end   <= on_bus.xe;
                    cmd_if.y_end   <= on_bus.ye;
                    cmd_if.color   <= on_bus.color;
                end
                else
                    cmd_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // pixel monitor: random backpressure, every transfer checked against the
    // oldest predicted pixel
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            pix_if.ready <= 1'b0;
        else
        begin
            pix_if.ready <= no_stall || ($urandom_range(0, 99) >= STALL_PERCENT);
            if (pix_if.valid && pix_if.ready)
            begin
                if (pixels_due.size() == 0)
                    report_mismatch($sformatf("pixel transfer with none expected, address %0h",
                                              pix_if.pixel_address));
                else
                begin
                    got_pixel = pixels_due.pop_front();
                    if (pix_if.pixel_valid !== got_pixel.valid)
                        report_mismatch($sformatf("pixel_valid %b, expected %b",
                                                  pix_if.pixel_valid, got_pixel.valid));
                    if (pix_if.pixel_address !== got_pixel.address)
                        report_mismatch($sformatf("pixel_address %0h, expected %0h",
                                                  pix_if.pixel_address, got_pixel.address));
                    if (pix_if.pixel_color !== got_pixel.color)
                        report_mismatch($sformatf("pixel_color %0h, expected %0h",
                                                  pix_if.pixel_color, got_pixel.color));
                    if (pix_if.last_pixel !== got_pixel.last)
                        report_mismatch($sformatf("last_pixel %b, expected %b",
                                                  pix_if.last_pixel, got_pixel.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles with no transfer on any channel
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((cmd_if.valid && cmd_if.ready) || (pix_if.valid && pix_if.ready) ||
                 (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    function automatic void push_start(int xs, int ys, int xe, int ye, int color);
        line_cmd_t c;
        c.op    = brl_pkg::OP_START;
        c.xs    = COORD_BITS'(xs);
        c.ys    = COORD_BITS'(ys);
        c.xe    = COORD_BITS'(xe);
        c.ye    = COORD_BITS'(ye);
        c.color = COLOR_BITS'(color);
        cmds_to_send.push_back(c);
    endfunction

    // step commands carry random coordinates and color, which the block ignores
    function automatic void push_steps(int count);
        line_cmd_t c;
        for (int i = 0; i < count; i++)
        begin
            c.op    = brl_pkg::OP_STEP;
            c.xs    = COORD_BITS'($urandom);
            c.ys    = COORD_BITS'($urandom);
            c.xe    = COORD_BITS'($urandom);
            c.ye    = COORD_BITS'($urandom);
            c.color = COLOR_BITS'($urandom);
            cmds_to_send.push_back(c);
        end
    endfunction

    // one line from a random start point; mostly walked to its end, some
    // abandoned before the end, some followed by steps with no line active
    task automatic plan_line(input int reach, output int pushed);
        int xs;
        int ys;
        int dx;
        int dy;
        int xe;
        int ye;
        int span;
        int walk;
        int shape;
        int span_limit;
        span_limit = ($urandom_range(0, 49) == 0) ? 400 : reach;
        xs    = $urandom_range(0, COORD_MAX);
        ys    = $urandom_range(0, COORD_MAX);
        dx    = int'($urandom_range(0, 2 * span_limit)) - span_limit;
        dy    = int'($urandom_range(0, 2 * span_limit)) - span_limit;
        shape = $urandom_range(0, 9);
        case (shape)
            0:                                    // single point
            begin
                dx = 0;
                dy = 0;
            end
            1: dy = 0;                            // horizontal
            2: dx = 0;                            // vertical
            3: dy = $urandom_range(0, 1) ? dx : -dx; // diagonal tie
            default: ;
        endcase
        xe   = clamp_coord(xs + dx);
        ye   = clamp_coord(ys + dy);
        span = (xe > xs ? xe - xs : xs - xe);
        if ((ye > ys ? ye - ys : ys - ye) > span)
            span = (ye > ys ? ye - ys : ys - ye);
        case ($urandom_range(0, 9))
            0:       walk = (span > 0) ? $urandom_range(0, span - 1) : 0;
            1:       walk = span + $urandom_range(1, 3);
            default: walk = span;
        endcase
        push_start(xs, ys, xe, ye, $urandom_range(0, 255));
        push_steps(walk);
        pushed = walk + 1;
    endtask

    // wait until every command went out and every pixel came back
    task automatic drain();
        while (cmds_to_send.size() != 0 || pixels_due.size() != 0 || cmd_if.valid)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // pitch is only changed with the block idle
    task automatic write_pitch(input logic [PITCH_BITS-1:0] value);
        drain();
        cfg_if.valid      <= 1'b1;
        cfg_if.line_pitch <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        lr_pitch = value;
        cfg_if.valid <= 1'b0;
    endtask

    // random lines up to a budget of commands; the sender pauses once halfway
    // until every pixel so far is back
    task automatic run_lines(input int budget, input int reach);
        int  pushed;
        int  added;
        bit  paused;
        pushed = 0;
        paused = 1'b0;
        while (pushed < budget)
        begin
            if (!paused && pushed >= budget / 2)
            begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 6)
            begin
                added = $urandom_range(1, 3);
                push_steps(added);
            end
            else
                plan_line(reach, added);
            pushed += added;
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        no_stall          = 1'b0;
        fail_count        = 0;
        cmd_if.valid      = 1'b0;
        cmd_if.op         = brl_pkg::OP_START;
        cmd_if.x_start    = '0;
        cmd_if.y_start    = '0;
        cmd_if.x_end      = '0;
        cmd_if.y_end      = '0;
        cmd_if.color      = '0;
        pix_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.line_pitch = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset pitch
        push_steps(1);                                      // step with no line
        push_start(0, 0, 0, 0, 0);                          // single point line
        push_steps(1);
        push_start(COORD_MAX, COORD_MAX, COORD_MAX - 4, COORD_MAX - 2, 255);
        push_steps(5);                                      // x major, both down, overrun
        push_start(0, COORD_MAX, COORD_MAX, 0, 8'hA5);      // tie, y major
        push_steps(2);                                      // abandoned by next start
        push_start(5, 5, 8, 5, 8'h3C);                      // horizontal
        push_steps(3);
        push_start(10, 10, 10, 7, 8'hC3);                   // vertical going up
        push_steps(3);
        push_start(COORD_MAX, 0, 0, COORD_MAX, 8'h5A);      // full span, abandoned
        push_steps(1);
        push_start(100, 200, 103, 202, 8'h81);
        push_steps(3);
        run_lines(180, 12);

        // wrapping addresses with the widest pitch
        write_pitch({PITCH_BITS{1'b1}});
        run_lines(200, 20);

        // one byte per row, no stalls on either side
        write_pitch(12'd1);
        no_stall <= 1'b1;
        run_lines(200, 8);
        drain();
        no_stall <= 1'b0;

        // zero pitch: rows collapse onto one address line
        write_pitch(12'd0);
        run_lines(200, 16);

        // top of the usual range, corner pixel hits the last address
        write_pitch(12'd2048);
        push_start(COORD_MAX - 2, COORD_MAX - 1, COORD_MAX, COORD_MAX, 8'hFF);
        push_steps(2);
        run_lines(200, 30);

        write_pitch(PITCH_BITS'($urandom_range(2, 4094)));
        run_lines(200, 24);

        drain();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/brl_pkg.sv
design/brl_ifs.sv
design/bresenham_line_rasterizer.sv
design/brl_checker.sv
dv/tb_top.sv
